@@ src/itnm_pkg.sv @@
// Shared constants and operation codes for the index tree node manager.
package itnm_pkg;

    localparam int NODES_DEF     = 64;
    localparam int ROOT_ID       = 1;
    localparam int FIRST_FREE_ID = 2;
    localparam int FUNC_W        = 3;
    localparam int PAYLOAD_W     = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_RD_PAY = 3'd1,
        FN_RD_PAR = 3'd2,
        FN_SIB    = 3'd3,
        FN_CHILD  = 3'd4,
        FN_DESC   = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        LK_PARENT,
        LK_CHILD,
        LK_NEXT,
        LK_PREV
    } t_link;

endpackage

@@ src/itnm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module itnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/index_tree_node_manager.sv @@
// Tree node table with free list: sequencer, link walker, node RAMs and output register.
// Reset: synchronous, then an init sweep writes all NODES+2 entries, one per cycle, not ready.
// Bad ids and unknown funcs go straight to S_DONE, reads pass S_RD first; S_DONE loads o_* once it is free.
// Each link walk is bounded by the table size; add follows its walk with the free-list and write states,
//   is-child reads the first child before walking; siblings and is-child may run two walks.
// One item at a time; the next item is taken while the previous result waits in o_*.
module index_tree_node_manager
    import itnm_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    parameter int ID_W  = $clog2(NODES + 2)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [ID_W-1:0]      i_id_a,
    input  logic [ID_W-1:0]      i_id_b,
    input  logic [PAYLOAD_W-1:0] i_payload_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ID_W-1:0]      o_result_id,
    output logic                 o_answer,
    output logic [PAYLOAD_W-1:0] o_payload_out,
    output logic                 o_bad_id
);

    localparam int            TABLE   = NODES + 2;
    localparam int            STEP_W  = $clog2(TABLE + 1);
    localparam logic [ID_W:0] TABLE_X = (ID_W + 1)'(TABLE);
    localparam logic [ID_W-1:0] LAST_ID = ID_W'(TABLE - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHILD,
        S_WALK,
        S_ADD_FRESH,
        S_ADD_FCHK,
        S_ADD_PCHILD,
        S_ADD_W1,
        S_ADD_W2,
        S_ADD_W3,
        S_DONE
    } t_state;

    function automatic logic f_ok(input logic [ID_W-1:0] x);
        return ({1'b0, x} < TABLE_X);
    endfunction

    t_state                r_state, n_state;
    t_func                 r_op, n_op;
    t_link                 r_link, n_link;
    logic                  r_phase, n_phase;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [ID_W-1:0]       r_a, n_a;
    logic [ID_W-1:0]       r_target, n_target;
    logic [ID_W-1:0]       r_fresh, n_fresh;
    logic [ID_W-1:0]       r_after, n_after;
    logic [ID_W-1:0]       r_after2, n_after2;
    logic [PAYLOAD_W-1:0]  r_pay, n_pay;
    logic [ID_W-1:0]       r_idx, n_idx;
    logic [ID_W-1:0]       r_res_rid, n_res_rid;
    logic                  r_res_ans, n_res_ans;
    logic [PAYLOAD_W-1:0]  r_res_pay, n_res_pay;
    logic                  r_res_bad, n_res_bad;
    logic                  r_o_valid, n_o_valid;
    logic [ID_W-1:0]       r_o_rid, n_o_rid;
    logic                  r_o_ans, n_o_ans;
    logic [PAYLOAD_W-1:0]  r_o_pay, n_o_pay;
    logic                  r_o_bad, n_o_bad;

    logic [ID_W-1:0]       rd_addr;
    logic [ID_W-1:0]       q_par, q_chd, q_nxt, q_prv;
    logic [PAYLOAD_W-1:0]  q_pay;
    logic                  we_par, we_chd, we_nxt, we_prv, we_pay;
    logic [ID_W-1:0]       wa_par, wa_chd, wa_nxt, wa_prv, wa_pay;
    logic [ID_W-1:0]       wd_par, wd_chd, wd_nxt, wd_prv;
    logic [PAYLOAD_W-1:0]  wd_pay;
    logic [ID_W-1:0]       cur;
    logic                  cur_ok;
    logic                  walk_fin, walk_found;
    logic                  out_free;
    logic                  a_ok, b_ok;

    itnm_ram #(.WIDTH(ID_W), .DEPTH(TABLE)) u_par (
        .i_clk(i_clk), .i_we(we_par), .i_waddr(wa_par), .i_wdata(wd_par),
        .i_raddr(rd_addr), .o_rdata(q_par)
    );
    itnm_ram #(.WIDTH(ID_W), .DEPTH(TABLE)) u_chd (
        .i_clk(i_clk), .i_we(we_chd), .i_waddr(wa_chd), .i_wdata(wd_chd),
        .i_raddr(rd_addr), .o_rdata(q_chd)
    );
    itnm_ram #(.WIDTH(ID_W), .DEPTH(TABLE)) u_nxt (
        .i_clk(i_clk), .i_we(we_nxt), .i_waddr(wa_nxt), .i_wdata(wd_nxt),
        .i_raddr(rd_addr), .o_rdata(q_nxt)
    );
    itnm_ram #(.WIDTH(ID_W), .DEPTH(TABLE)) u_prv (
        .i_clk(i_clk), .i_we(we_prv), .i_waddr(wa_prv), .i_wdata(wd_prv),
        .i_raddr(rd_addr), .o_rdata(q_prv)
    );
    itnm_ram #(.WIDTH(PAYLOAD_W), .DEPTH(TABLE)) u_pay (
        .i_clk(i_clk), .i_we(we_pay), .i_waddr(wa_pay), .i_wdata(wd_pay),
        .i_raddr(rd_addr), .o_rdata(q_pay)
    );

    always_comb begin
        unique case (r_link)
            LK_PARENT: cur = q_par;
            LK_CHILD:  cur = q_chd;
            LK_NEXT:   cur = q_nxt;
            LK_PREV:   cur = q_prv;
            default:   cur = q_par;
        endcase
    end

    assign cur_ok     = (cur != '0) && f_ok(cur);
    assign walk_fin   = (r_step == STEP_W'(TABLE)) || !cur_ok || (cur == r_target);
    assign walk_found = (r_step != STEP_W'(TABLE)) && cur_ok && (cur == r_target);
    assign out_free   = !r_o_valid || i_out_ready;
    assign a_ok       = f_ok(i_id_a);
    assign b_ok       = f_ok(i_id_b);

    // RAM write ports
    always_comb begin
        we_par = 1'b0; wa_par = '0; wd_par = '0;
        we_chd = 1'b0; wa_chd = '0; wd_chd = '0;
        we_nxt = 1'b0; wa_nxt = '0; wd_nxt = '0;
        we_prv = 1'b0; wa_prv = '0; wd_prv = '0;
        we_pay = 1'b0; wa_pay = '0; wd_pay = '0;
        unique case (r_state)
            S_INIT: begin
                we_par = 1'b1; wa_par = r_idx;
                we_chd = 1'b1; wa_chd = r_idx;
                we_nxt = 1'b1; wa_nxt = r_idx;
                we_prv = 1'b1; wa_prv = r_idx;
                we_pay = 1'b1; wa_pay = r_idx;
                if (r_idx == ID_W'(ROOT_ID)) begin
                    wd_par = ID_W'(ROOT_ID);
                end
                if (r_idx == '0) begin
                    wd_nxt = ID_W'(FIRST_FREE_ID);
                    wd_prv = LAST_ID;
                end else begin
                    if (r_idx >= ID_W'(FIRST_FREE_ID) && r_idx != LAST_ID) begin
                        wd_nxt = r_idx + ID_W'(1);
                    end
                    if (r_idx > ID_W'(FIRST_FREE_ID)) begin
                        wd_prv = r_idx - ID_W'(1);
                    end
                end
            end
            S_ADD_W1: begin
                we_prv = (r_after != '0) && f_ok(r_after);
                wa_prv = r_after;
                we_nxt = 1'b1; wa_nxt = '0;      wd_nxt = r_after;
                we_pay = 1'b1; wa_pay = r_fresh; wd_pay = r_pay;
                we_par = 1'b1; wa_par = r_fresh; wd_par = r_a;
            end
            S_ADD_W2: begin
                we_prv = 1'b1; wa_prv = r_fresh;
                we_nxt = 1'b1; wa_nxt = r_fresh; wd_nxt = r_after2;
                we_chd = 1'b1; wa_chd = r_a;     wd_chd = r_fresh;
            end
            S_ADD_W3: begin
                we_prv = (r_after2 != '0) && f_ok(r_after2);
                wa_prv = r_after2;
                wd_prv = r_fresh;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_link    = r_link;
        n_phase   = r_phase;
        n_step    = r_step;
        n_a       = r_a;
        n_target  = r_target;
        n_fresh   = r_fresh;
        n_after   = r_after;
        n_after2  = r_after2;
        n_pay     = r_pay;
        n_idx     = r_idx;
        n_res_rid = r_res_rid;
        n_res_ans = r_res_ans;
        n_res_pay = r_res_pay;
        n_res_bad = r_res_bad;
        n_o_rid   = r_o_rid;
        n_o_ans   = r_o_ans;
        n_o_pay   = r_o_pay;
        n_o_bad   = r_o_bad;
        n_o_valid = r_o_valid && !i_out_ready;
        rd_addr   = '0;

        unique case (r_state)
            S_INIT: begin
                n_idx = r_idx + ID_W'(1);
                if (r_idx == LAST_ID) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = t_func'(i_func);
                    n_a       = i_id_a;
                    n_pay     = i_payload_in;
                    n_step    = '0;
                    n_phase   = 1'b0;
                    n_res_rid = '0;
                    n_res_ans = 1'b0;
                    n_res_pay = '0;
                    n_res_bad = 1'b0;
                    n_state   = S_DONE;
                    unique case (t_func'(i_func))
                        FN_ADD: begin
                            if (!a_ok) begin
                                n_res_bad = 1'b1;
                            end else if (i_id_a != '0) begin
                                rd_addr  = i_id_a;
                                n_link   = LK_PARENT;
                                n_target = ID_W'(ROOT_ID);
                                n_state  = S_WALK;
                            end
                        end
                        FN_RD_PAY, FN_RD_PAR: begin
                            if (!b_ok) begin
                                n_res_bad = 1'b1;
                            end else begin
                                rd_addr = i_id_b;
                                n_state = S_RD;
                            end
                        end
                        FN_SIB, FN_CHILD, FN_DESC: begin
                            n_target = i_id_b;
                            if (!a_ok || !b_ok) begin
                                n_res_bad = 1'b1;
                            end else if (t_func'(i_func) == FN_SIB) begin
                                rd_addr = i_id_a;
                                n_link  = LK_NEXT;
                                n_state = S_WALK;
                            end else if (t_func'(i_func) == FN_CHILD) begin
                                rd_addr = i_id_a;
                                n_state = S_CHILD;
                            end else begin
                                rd_addr  = i_id_b;
                                n_target = i_id_a;
                                n_link   = LK_PARENT;
                                n_state  = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_op == FN_RD_PAY) begin
                    n_res_pay = q_pay;
                end else begin
                    n_res_rid = q_par;
                end
                n_state = S_DONE;
            end
            S_CHILD: begin
                if (q_chd == '0) begin
                    n_state = S_DONE;
                end else if (q_chd == r_target) begin
                    n_res_ans = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_a     = q_chd;
                    rd_addr = q_chd;
                    n_link  = LK_NEXT;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!walk_fin) begin
                    rd_addr = cur;
                    n_step  = r_step + STEP_W'(1);
                end else begin
                    n_state = S_DONE;
                    unique case (r_op)
                        FN_ADD: begin
                            if (walk_found) begin
                                rd_addr = '0;
                                n_state = S_ADD_FRESH;
                            end
                        end
                        FN_SIB, FN_CHILD: begin
                            if (walk_found) begin
                                n_res_ans = 1'b1;
                            end else if (!r_phase) begin
                                rd_addr = r_a;
                                n_link  = LK_PREV;
                                n_phase = 1'b1;
                                n_step  = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_res_ans = walk_found;
                        end
                    endcase
                end
            end
            S_ADD_FRESH: begin
                if (q_nxt == '0 || !f_ok(q_nxt)) begin
                    n_state = S_DONE;
                end else begin
                    n_fresh = q_nxt;
                    rd_addr = q_nxt;
                    n_state = S_ADD_FCHK;
                end
            end
            S_ADD_FCHK: begin
                if (q_chd != '0) begin
                    n_state = S_DONE;
                end else begin
                    n_after = q_nxt;
                    rd_addr = r_a;
                    n_state = S_ADD_PCHILD;
                end
            end
            S_ADD_PCHILD: begin
                n_after2 = q_chd;
                n_state  = S_ADD_W1;
            end
            S_ADD_W1: n_state = S_ADD_W2;
            S_ADD_W2: n_state = S_ADD_W3;
            S_ADD_W3: begin
                n_res_rid = r_fresh;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_rid   = r_res_rid;
                    n_o_ans   = r_res_ans;
                    n_o_pay   = r_res_pay;
                    n_o_bad   = r_res_bad;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
        end
        r_op      <= n_op;
        r_link    <= n_link;
        r_phase   <= n_phase;
        r_step    <= n_step;
        r_a       <= n_a;
        r_target  <= n_target;
        r_fresh   <= n_fresh;
        r_after   <= n_after;
        r_after2  <= n_after2;
        r_pay     <= n_pay;
        r_res_rid <= n_res_rid;
        r_res_ans <= n_res_ans;
        r_res_pay <= n_res_pay;
        r_res_bad <= n_res_bad;
        r_o_rid   <= n_o_rid;
        r_o_ans   <= n_o_ans;
        r_o_pay   <= n_o_pay;
        r_o_bad   <= n_o_bad;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_result_id   = r_o_rid;
    assign o_answer      = r_o_ans;
    assign o_payload_out = r_o_pay;
    assign o_bad_id      = r_o_bad;

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_id) |->
            (o_result_id == '0 && !o_answer && o_payload_out == '0))
        else $error("bad id result carries nonzero fields");

    a_rid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> f_ok(o_result_id))
        else $error("result id outside node table");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step <= STEP_W'(TABLE)))
        else $error("walk ran past table size");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat left sequencer idle");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && !i_out_ready) |=>
            (r_state == S_DONE && $stable(o_result_id) && $stable(o_payload_out)))
        else $error("result overwritten while output stalled");

endmodule
